// ===== src/spq_pkg.sv =====
// Shared types, constants and codes for the stable priority queue.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 16;
	localparam int OCC_W    = 5;

	typedef logic [DATA_W-1:0]        data_t;
	typedef logic signed [PRIO_W-1:0] prio_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [OCC_W-1:0]         occ_t;

	localparam prio_t PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_e;

	typedef enum logic [1:0] {
		STAT_ENQ   = 2'd0,
		STAT_DEQ   = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FULL  = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_SHIFT,
		ST_DONE
	} state_e;

	typedef struct packed {
		data_t value;
		prio_t prio;
	} entry_t;

	// Store access issued by the sequencer each cycle.
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		idx_t   raddr;
	} mem_req_t;

	typedef struct packed {
		data_t   data;
		status_e status;
		occ_t    occ;
	} result_t;

endpackage

`default_nettype wire

// ===== src/spq_if.sv =====
// Request and response channel interfaces of the stable priority queue.
// Depends on spq_pkg for field types.
`default_nettype none

interface spq_req_if;
	logic           valid;
	logic           ready;
	logic           command;
	spq_pkg::data_t data_in;
	spq_pkg::prio_t priority_req;

	modport source (output valid, output command, output data_in, output priority_req,
		input ready);
	modport sink (input valid, input command, input data_in, input priority_req,
		output ready);
endinterface

interface spq_rsp_if;
	logic           valid;
	logic           ready;
	spq_pkg::data_t data_out;
	logic [1:0]     status;
	spq_pkg::occ_t  occupancy;

	modport source (output valid, output data_out, output status, output occupancy,
		input ready);
	modport sink (input valid, input data_out, input status, input occupancy,
		output ready);
endinterface

`default_nettype wire

// ===== src/spq_store.sv =====
// Entry store: one write port and one read port with registered read data.
// Depends on spq_pkg. Contents are undefined until written.
`default_nettype none

module spq_store (
	input  wire logic              clk,
	input  wire spq_pkg::mem_req_t mem_req,
	output spq_pkg::entry_t        rdata
);

	spq_pkg::entry_t mem_q [spq_pkg::CAPACITY];
	spq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[mem_req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/spq_seq.sv =====
// Sequencer: takes one request; for a dequeue it walks the entry store
// one entry a cycle, finds the oldest maximum, closes the gap and rebuilds
// the maximum. Depends on spq_pkg and drives spq_store through a mem_req_t.
`default_nettype none

module spq_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cmd,
	input  wire spq_pkg::data_t    data,
	input  wire spq_pkg::prio_t    prio,
	input  wire spq_pkg::entry_t   rdata,
	output spq_pkg::mem_req_t      mem_req,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output spq_pkg::result_t       res
);

	spq_pkg::state_e  state_q, state_d;
	spq_pkg::cnt_t    count_q;
	spq_pkg::prio_t   high_q;
	spq_pkg::prio_t   acc_q;
	spq_pkg::idx_t    idx_q;
	spq_pkg::result_t res_q;

	logic              accept;
	logic              is_deq;
	logic              full;
	logic              empty;
	logic              hit;
	logic              last;
	logic              finish;
	spq_pkg::prio_t    acc_d;
	spq_pkg::idx_t     idx_inc;
	spq_pkg::status_e  idle_status;
	spq_pkg::occ_t     idle_occ;

	assign accept  = in_valid && in_ready;
	assign is_deq  = (cmd == spq_pkg::CMD_DEQ);
	assign full    = (count_q == spq_pkg::cnt_t'(spq_pkg::CAPACITY));
	assign empty   = (count_q == '0);
	assign idx_inc = spq_pkg::idx_t'(idx_q + spq_pkg::idx_t'(1));

	// Shared compare unit: one stored entry per cycle.
	always_comb begin
		hit   = (rdata.prio == high_q);
		last  = ((spq_pkg::cnt_t'(idx_q) + spq_pkg::cnt_t'(1)) == count_q);
		acc_d = (rdata.prio > acc_q) ? rdata.prio : acc_q;
		unique case (state_q)
			spq_pkg::ST_FIND:  finish = (hit || last) && last;
			spq_pkg::ST_SHIFT: finish = last;
			default:           finish = 1'b0;
		endcase
	end

	// Status and fill level of the request offered while idle
	always_comb begin
		idle_status = spq_pkg::STAT_ENQ;
		idle_occ    = spq_pkg::occ_t'(count_q);
		if (is_deq) begin
			if (empty) begin
				idle_status = spq_pkg::STAT_EMPTY;
			end else begin
				idle_status = spq_pkg::STAT_DEQ;
			end
		end else if (full) begin
			idle_status = spq_pkg::STAT_FULL;
		end else begin
			idle_occ = spq_pkg::occ_t'(count_q + spq_pkg::cnt_t'(1));
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (is_deq && !empty) ? spq_pkg::ST_FIND : spq_pkg::ST_DONE;
				end
			end
			spq_pkg::ST_FIND: begin
				if (hit || last) begin
					state_d = last ? spq_pkg::ST_DONE : spq_pkg::ST_SHIFT;
				end
			end
			spq_pkg::ST_SHIFT: begin
				if (last) begin
					state_d = spq_pkg::ST_DONE;
				end
			end
			spq_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = spq_pkg::ST_IDLE;
				end
			end
			default: state_d = spq_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q;
		mem_req.wdata = rdata;
		mem_req.raddr = idx_inc;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				mem_req.raddr = '0;
				mem_req.we    = accept && !is_deq && !full;
				mem_req.waddr = spq_pkg::idx_t'(count_q);
				mem_req.wdata = '{value: data, prio: prio};
			end
			spq_pkg::ST_SHIFT: begin
				// entry idx moves down into the gap at idx-1
				mem_req.we    = 1'b1;
				mem_req.waddr = spq_pkg::idx_t'(idx_q - spq_pkg::idx_t'(1));
			end
			spq_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
			count_q <= '0;
			high_q  <= spq_pkg::PRIO_MIN;
		end else begin
			state_q <= state_d;
			if (state_q == spq_pkg::ST_IDLE && accept && !is_deq && !full) begin
				count_q <= count_q + spq_pkg::cnt_t'(1);
				if (empty || prio > high_q) begin
					high_q <= prio;
				end
			end
			if ((state_q == spq_pkg::ST_FIND && hit && last) ||
			    (state_q == spq_pkg::ST_FIND && !hit && last) ||
			    (state_q == spq_pkg::ST_SHIFT && last)) begin
				count_q <= count_q - spq_pkg::cnt_t'(1);
				// the removed entry never enters the accumulator
				high_q  <= (state_q == spq_pkg::ST_SHIFT) ? acc_d : acc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				idx_q <= '0;
				acc_q <= spq_pkg::PRIO_MIN;
				res_q <= '{data: '0, status: idle_status, occ: idle_occ};
			end
			spq_pkg::ST_FIND: begin
				if (hit || last) begin
					res_q <= '{data: rdata.value, status: res_q.status,
						occ: spq_pkg::occ_t'(count_q - spq_pkg::cnt_t'(1))};
				end else begin
					acc_q <= acc_d;
				end
				idx_q <= idx_inc;
			end
			spq_pkg::ST_SHIFT: begin
				acc_q <= acc_d;
				idx_q <= idx_inc;
			end
			spq_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	assign res = res_q;

	// finish is only a helper for the checks below
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::cnt_t'(spq_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_shift_writes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spq_pkg::ST_SHIFT |-> mem_req.we)
		else $error("shift cycle without store write");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> state_q == spq_pkg::ST_DONE && count_q == $past(count_q) - 1'b1)
		else $error("scan end did not retire one entry");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> state_q == spq_pkg::ST_IDLE)
		else $error("result handed off but sequencer not idle");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && res_valid))
		else $error("request taken while a result is pending");

endmodule

`default_nettype wire

// ===== src/stable_priority_queue.sv =====
// Top level of the stable priority queue: sequencer, entry store and the
// response output register. Depends on spq_pkg, spq_if, spq_store, spq_seq.
//
//   channel | dir | payload
//   req     | in  | command, data_in, priority_req
//   rsp     | out | data_out, status, occupancy
//
// Enqueue, full enqueue and empty dequeue go from IDLE straight to DONE;
// other dequeues run FIND, then SHIFT if entries follow the maximum, and
// the entry store's single read port visits each held entry once (find,
// then close the gap). Reset clears count, maximum and handshake state;
// entry contents stay undefined and need no clearing pass.
// A stalled rsp holds its result; the next request is taken meanwhile.
`default_nettype none

module stable_priority_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	spq_pkg::mem_req_t mem_req;
	spq_pkg::entry_t   rdata;
	spq_pkg::result_t  res;
	spq_pkg::result_t  out_q;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid_q;

	spq_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	spq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.cmd       (req.command),
		.data      (req.data_in),
		.prio      (req.priority_req),
		.rdata     (rdata),
		.mem_req   (mem_req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data_out  = out_q.data;
	assign rsp.status    = out_q.status;
	assign rsp.occupancy = out_q.occ;

endmodule

`default_nettype wire
